// ===== rtl/fbrf_pkg.sv =====
package fbrf_pkg;

  // Frame store size in bytes. It must be a power of two: pixel addresses
  // wrap by dropping the bits above ADDR_W.
  localparam int STORE_BYTES = 65536;
  localparam int ADDR_W      = $clog2(STORE_BYTES);

  // Width of the dimension fields and of the walker counters.
  localparam int DIM_W = 11;

  // The row buffer holds one whole row of the widest surface.
  localparam int ROW_BUF = 2 ** DIM_W;
  localparam int RB_AW   = DIM_W;

  // Bits of the row address product before wrapping: 12-bit row times
  // 11-bit stride plus an 11-bit column.
  localparam int PROD_W = 24;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'b1;

  // Register values after reset.
  localparam logic [DIM_W-1:0] RESET_WIDTH  = 11'd320;
  localparam logic [DIM_W-1:0] RESET_HEIGHT = 11'd200;

  // The masked fill only ever touches the low four planes.
  localparam logic [3:0] PLANE_ALL = 4'hF;

  typedef enum logic [2:0] {
    REQ_READ   = 3'd0,
    REQ_FILL   = 3'd1,
    REQ_MFILL  = 3'd2,
    REQ_COPY   = 3'd3,
    REQ_SCROLL = 3'd4
  } req_t;

endpackage

// ===== rtl/fbrf_ram.sv =====
// Simple dual-port RAM: one write port, one registered read port. A read of
// the address written in the same cycle returns the new data.
module fbrf_ram #(
  parameter int DEPTH  = 256,
  parameter int DATA_W = 8,
  parameter int AW     = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rd_data_r;
  logic [DATA_W-1:0] fwd_data_r;
  logic              fwd_hit_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_data_r  <= mem_r[raddr];
      fwd_hit_r  <= we && (waddr == raddr);
      fwd_data_r <= wdata;
    end
  end

  assign rdata = fwd_hit_r ? fwd_data_r : rd_data_r;

endmodule

// ===== rtl/framebuffer_rect_fill_copy_engine.sv =====
// Rectangle fill and copy engine over an 8-bit-per-pixel frame store.
// One command arrives per input transaction (kind on in_tuser, operands on
// in_tdata) and yields exactly one result transaction (pixel byte on
// out_tdata, reject flag on out_tuser). Pixel (x, y) lives at store address
// (y * surface_width + x) modulo the store size.
// The user must set the surface size through the cfg_ write port only
// while the block is idle; the block does not enforce this. Reset restores
// 320 by 200; the store is undefined until written, with no clearing pass.
// Flow: a command is taken only when the engine is idle. A fill writes one
// pixel per cycle and a masked fill the same, as the read-modify-write is
// pipelined over the single store read port. A copy or scroll moves each
// row through the row buffer in full before it is written back, at one
// pixel per cycle in each of the read and write passes.
// The result sits in an output register: a stalled receiver does not stop
// the next command being taken, but that command cannot deliver its result
// until the previous one has been consumed.
module framebuffer_rect_fill_copy_engine
  import fbrf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // dest_x[9:0], dest_y[19:10], src_x[29:20], src_y[39:30], rect_w[50:40],
  // rect_h[61:51], fill_colour[69:62], plane_mask[73:70], shift_x[85:74],
  // shift_y[97:86], zero padding above
  input  logic [103:0]         in_tdata,
  // req_type[2:0]
  input  logic [2:0]           in_tuser,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // pixel_value[7:0]
  output logic [7:0]           out_tdata,
  // status[0]
  output logic                 out_tuser,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data
);

  typedef enum logic [11:0] {
    S_IDLE     = 12'b0000_0000_0001,
    S_CHECK    = 12'b0000_0000_0010,
    S_BASE     = 12'b0000_0000_0100,
    S_BASE2    = 12'b0000_0000_1000,
    S_RD_ISSUE = 12'b0000_0001_0000,
    S_RD_DATA  = 12'b0000_0010_0000,
    S_FILL     = 12'b0000_0100_0000,
    S_MFILL    = 12'b0000_1000_0000,
    S_CPY_RD   = 12'b0001_0000_0000,
    S_CPY_WR   = 12'b0010_0000_0000,
    S_DONE     = 12'b0100_0000_0000
  } state_t;

  // What the write stage does with the data that the read stage fetched.
  typedef enum logic [1:0] {
    PK_RB    = 2'd0,
    PK_MERGE = 2'd1,
    PK_COPY  = 2'd2,
    PK_FILL  = 2'd3
  } pend_t;

  state_t state_r, state_nxt;

  logic [DIM_W-1:0] surf_w_r;
  logic [DIM_W-1:0] surf_h_r;

  // Command operands. Scroll rewrites them into an equivalent copy.
  req_t             type_r;
  logic [DIM_W-1:0] x_r, y_r, sx_r, sy_r, w_r, h_r;
  logic [7:0]       colour_r;
  logic [3:0]       mask_r;
  logic [11:0]      shx_r, shy_r;

  logic       res_stat_r;
  logic [7:0] res_pix_r;

  logic       out_tvalid_r;
  logic [7:0] out_tdata_r;
  logic       out_tuser_r;

  // Rectangle walker.
  logic [DIM_W-1:0]  col_r;
  logic [DIM_W-1:0]  rows_left_r;
  logic [ADDR_W-1:0] d_row_r;
  logic [ADDR_W-1:0] s_row_r;
  logic              topdown_r;

  // Write stage, which follows the reads in the next cycle.
  logic              pend_vld_r;
  pend_t             pend_kind_r;
  logic [ADDR_W-1:0] pend_addr_r;
  logic [RB_AW-1:0]  pend_idx_r;

  logic              in_acc;
  logic              out_free;
  logic              last_col, last_row;
  logic              is_copy;
  logic [11:0]       x_end, y_end, sx_end, sy_end;
  logic              fits_d, fits_s, empty;
  logic [11:0]       ax, ay;
  logic              scroll_ok;
  logic              check_go, check_rej;
  logic              td;
  logic [11:0]       ydst, ysrc, mul_y;
  logic [DIM_W-1:0]  mul_x;
  logic [PROD_W-1:0] mul_full;
  logic [ADDR_W-1:0] row_addr;
  logic [ADDR_W-1:0] d_pix, s_pix;
  logic [ADDR_W-1:0] d_step, s_step;
  logic [7:0]        mask8;

  logic              fs_we, fs_re;
  logic [ADDR_W-1:0] fs_waddr, fs_raddr;
  logic [7:0]        fs_wdata, fs_rdata;
  logic              rb_we, rb_re;
  logic [RB_AW-1:0]  rb_waddr, rb_raddr;
  logic [7:0]        rb_wdata, rb_rdata;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_free   = !out_tvalid_r || out_tready;

  assign last_col = (col_r == (w_r - 11'd1));
  assign last_row = (rows_left_r == 11'd1);
  assign is_copy  = (type_r == REQ_COPY) || (type_r == REQ_SCROLL);

  // Bounds and scroll geometry, evaluated in the check cycle.
  assign x_end  = {1'b0, x_r} + {1'b0, w_r};
  assign y_end  = {1'b0, y_r} + {1'b0, h_r};
  assign sx_end = {1'b0, sx_r} + {1'b0, w_r};
  assign sy_end = {1'b0, sy_r} + {1'b0, h_r};
  assign fits_d = (x_end <= {1'b0, surf_w_r}) && (y_end <= {1'b0, surf_h_r});
  assign fits_s = (sx_end <= {1'b0, surf_w_r}) && (sy_end <= {1'b0, surf_h_r});
  assign empty  = (w_r == '0) || (h_r == '0);

  // Magnitude of a 12-bit two's complement shift; the most negative value
  // gives 2048, which still reads correctly as unsigned.
  assign ax = shx_r[11] ? 12'(-shx_r) : shx_r;
  assign ay = shy_r[11] ? 12'(-shy_r) : shy_r;
  assign scroll_ok = (ax < {1'b0, surf_w_r}) && (ay < {1'b0, surf_h_r});

  always_comb begin
    check_go  = 1'b0;
    check_rej = 1'b0;
    case (type_r)
      REQ_READ: begin
        check_go  = (x_r < surf_w_r) && (y_r < surf_h_r);
        check_rej = !check_go;
      end
      REQ_FILL, REQ_MFILL: begin
        check_go  = !empty && fits_d;
        check_rej = !empty && !fits_d;
      end
      REQ_COPY: begin
        check_go  = !empty && fits_d && fits_s;
        check_rej = !empty && !(fits_d && fits_s);
      end
      REQ_SCROLL: begin
        check_go = scroll_ok;
      end
      default: begin
        check_go = 1'b0;
      end
    endcase
  end

  // Rows run top-down when the source lies below the destination, else
  // bottom-up, so an overlapping copy never reads a row it already wrote.
  assign td   = !is_copy || (sy_r > y_r);
  assign ydst = td ? {1'b0, y_r} : 12'({1'b0, y_r} + {1'b0, h_r} - 12'd1);
  assign ysrc = topdown_r ? {1'b0, sy_r} : 12'({1'b0, sy_r} + {1'b0, h_r} - 12'd1);

  // One shared multiplier forms the start row address of the destination in
  // the first base cycle and of the source in the second.
  assign mul_y    = (state_r == S_BASE2) ? ysrc : ydst;
  assign mul_x    = (state_r == S_BASE2) ? sx_r : x_r;
  assign mul_full = ({12'd0, mul_y} * {13'd0, surf_w_r}) + {13'd0, mul_x};
  assign row_addr = mul_full[ADDR_W-1:0];

  assign d_pix  = ADDR_W'(d_row_r + col_r);
  assign s_pix  = ADDR_W'(s_row_r + col_r);
  assign d_step = topdown_r ? ADDR_W'(d_row_r + surf_w_r) : ADDR_W'(d_row_r - surf_w_r);
  assign s_step = topdown_r ? ADDR_W'(s_row_r + surf_w_r) : ADDR_W'(s_row_r - surf_w_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        state_nxt = check_go ? S_BASE : S_DONE;
      end
      S_BASE: begin
        case (type_r)
          REQ_READ:  state_nxt = S_RD_ISSUE;
          REQ_FILL:  state_nxt = S_FILL;
          REQ_MFILL: state_nxt = S_MFILL;
          default:   state_nxt = S_BASE2;
        endcase
      end
      S_BASE2: begin
        state_nxt = S_CPY_RD;
      end
      S_RD_ISSUE: begin
        state_nxt = S_RD_DATA;
      end
      S_RD_DATA: begin
        state_nxt = S_DONE;
      end
      S_FILL, S_MFILL: begin
        if (last_col && last_row) begin
          state_nxt = S_DONE;
        end
      end
      S_CPY_RD: begin
        if (last_col) begin
          state_nxt = S_CPY_WR;
        end
      end
      S_CPY_WR: begin
        if (last_col) begin
          state_nxt = last_row ? S_DONE : S_CPY_RD;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      surf_w_r <= RESET_WIDTH;
      surf_h_r <= RESET_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WIDTH:  surf_w_r <= cfg_data;
        CFG_HEIGHT: surf_h_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Command capture, the scroll rewrite and the result fields.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      type_r     <= req_t'(in_tuser);
      x_r        <= {1'b0, in_tdata[9:0]};
      y_r        <= {1'b0, in_tdata[19:10]};
      sx_r       <= {1'b0, in_tdata[29:20]};
      sy_r       <= {1'b0, in_tdata[39:30]};
      w_r        <= in_tdata[50:40];
      h_r        <= in_tdata[61:51];
      colour_r   <= in_tdata[69:62];
      mask_r     <= in_tdata[73:70] & PLANE_ALL;
      shx_r      <= in_tdata[85:74];
      shy_r      <= in_tdata[97:86];
      res_stat_r <= 1'b0;
      res_pix_r  <= 8'd0;
    end else if (state_r == S_CHECK) begin
      res_stat_r <= check_rej;
      if (type_r == REQ_SCROLL && scroll_ok) begin
        // A positive shift moves content left or up: the source starts at
        // the shift and the destination at zero, and the other way round.
        if (!shx_r[11] && shx_r != 12'd0) begin
          x_r  <= '0;
          sx_r <= ax[DIM_W-1:0];
        end else begin
          x_r  <= ax[DIM_W-1:0];
          sx_r <= '0;
        end
        if (!shy_r[11] && shy_r != 12'd0) begin
          y_r  <= '0;
          sy_r <= ay[DIM_W-1:0];
        end else begin
          y_r  <= ay[DIM_W-1:0];
          sy_r <= '0;
        end
        w_r <= DIM_W'(surf_w_r - ax[DIM_W-1:0]);
        h_r <= DIM_W'(surf_h_r - ay[DIM_W-1:0]);
      end
    end else if (state_r == S_RD_DATA) begin
      res_pix_r <= fs_rdata;
    end
  end

  // Rectangle walker: column within the row, rows still to do, and the
  // wrapped start addresses of the current destination and source rows.
  always_ff @(posedge clk) begin
    case (state_r)
      S_BASE: begin
        col_r       <= '0;
        rows_left_r <= h_r;
        d_row_r     <= row_addr;
        topdown_r   <= td;
      end
      S_BASE2: begin
        s_row_r <= row_addr;
      end
      S_FILL, S_MFILL: begin
        if (last_col) begin
          col_r <= '0;
          if (!last_row) begin
            rows_left_r <= rows_left_r - 11'd1;
            d_row_r     <= d_step;
          end
        end else begin
          col_r <= col_r + 11'd1;
        end
      end
      S_CPY_RD: begin
        col_r <= last_col ? '0 : col_r + 11'd1;
      end
      S_CPY_WR: begin
        if (last_col) begin
          col_r <= '0;
          if (!last_row) begin
            rows_left_r <= rows_left_r - 11'd1;
            d_row_r     <= d_step;
            s_row_r     <= s_step;
          end
        end else begin
          col_r <= col_r + 11'd1;
        end
      end
      default: ;
    endcase
  end

  // Read side of each walking state. Fetched data lands in the write stage
  // in the next cycle, together with where it must go.
  always_comb begin
    fs_re    = 1'b0;
    fs_raddr = d_pix;
    rb_re    = 1'b0;
    rb_raddr = col_r;
    case (state_r)
      S_RD_ISSUE: begin
        fs_re    = 1'b1;
        fs_raddr = d_row_r;
      end
      S_MFILL: begin
        fs_re = 1'b1;
      end
      S_CPY_RD: begin
        fs_re    = 1'b1;
        fs_raddr = s_pix;
      end
      S_CPY_WR: begin
        rb_re = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_vld_r <= 1'b0;
    end else begin
      pend_vld_r <= state_r inside {S_FILL, S_MFILL, S_CPY_RD, S_CPY_WR};
    end
  end

  always_ff @(posedge clk) begin
    pend_addr_r <= d_pix;
    pend_idx_r  <= col_r;
    case (state_r)
      S_MFILL:  pend_kind_r <= PK_MERGE;
      S_CPY_RD: pend_kind_r <= PK_RB;
      S_CPY_WR: pend_kind_r <= PK_COPY;
      default:  pend_kind_r <= PK_FILL;
    endcase
  end

  assign mask8 = {4'd0, mask_r};

  // Write stage. Both RAMs forward a same-cycle write to a read of the same
  // entry, which covers a row end meeting the next row start in a copy.
  always_comb begin
    case (pend_kind_r)
      PK_MERGE: fs_wdata = (fs_rdata & ~mask8) | (colour_r & mask8);
      PK_COPY:  fs_wdata = rb_rdata;
      default:  fs_wdata = colour_r;
    endcase
  end

  assign fs_we    = pend_vld_r && (pend_kind_r != PK_RB);
  assign fs_waddr = pend_addr_r;
  assign rb_we    = pend_vld_r && (pend_kind_r == PK_RB);
  assign rb_waddr = pend_idx_r;
  assign rb_wdata = fs_rdata;

  fbrf_ram #(
    .DEPTH  (STORE_BYTES),
    .DATA_W (8)
  ) u_frame_store (
    .clk   (clk),
    .we    (fs_we),
    .waddr (fs_waddr),
    .wdata (fs_wdata),
    .re    (fs_re),
    .raddr (fs_raddr),
    .rdata (fs_rdata)
  );

  fbrf_ram #(
    .DEPTH  (ROW_BUF),
    .DATA_W (8)
  ) u_row_buf (
    .clk   (clk),
    .we    (rb_we),
    .waddr (rb_waddr),
    .wdata (rb_wdata),
    .re    (rb_re),
    .raddr (rb_raddr),
    .rdata (rb_rdata)
  );

  // Output register: loaded from the done state once the previous result
  // has been taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (state_r == S_DONE && out_free) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      out_tdata_r <= res_pix_r;
      out_tuser_r <= res_stat_r;
    end
  end

  // The write stage has always drained by the time a new command can start.
  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !pend_vld_r)
    else $error("write stage still busy while idle");

  // A result only appears as the end of a command.
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> ($past(state_r) == S_DONE))
    else $error("result produced outside the done state");

  // The walker stays inside the rectangle.
  a_walker_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FILL || state_r == S_MFILL || state_r == S_CPY_RD ||
     state_r == S_CPY_WR) |-> (col_r < w_r && rows_left_r != '0))
    else $error("walker left the rectangle");

  // Nothing is written to the store before a command has passed its checks.
  a_no_early_write: assert property (@(posedge clk) disable iff (!rst_n)
    fs_we |-> (state_r != S_IDLE && state_r != S_CHECK))
    else $error("store written outside a command");

endmodule

// ===== verif/testbench.sv =====
module testbench;
  import fbrf_pkg::*;

  // Command kinds that the engine does not know. It must answer them with a
  // plain "done" and leave the frame store alone.
  localparam logic [2:0] KIND_RESERVED_LO = 3'd5;
  localparam logic [2:0] KIND_RESERVED_HI = 3'd7;

  // Random rectangles that would really run are capped at this many pixels,
  // so that the run stays within a sensible number of cycles.
  localparam int unsigned AREA_CAP = 4096;

  localparam int unsigned ITEMS_PER_PHASE = 128;
  localparam int unsigned RANDOM_PHASES   = 12;
  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned HOLD_AFTER      = 400;
  localparam int unsigned HOLD_CYCLES     = 500;
  localparam longint     TIMEOUT_UNITS    = 64'd50_000_000;

  // One command as it travels over the input channel. The fields are
  // listed from the top of in_tdata down, so the packing below reads the
  // same way.
  typedef struct packed {
    logic [2:0]         kind;
    logic signed [11:0] shy;
    logic signed [11:0] shx;
    logic [3:0]         mask;
    logic [7:0]         colour;
    logic [10:0]        h;
    logic [10:0]        w;
    logic [9:0]         sy;
    logic [9:0]         sx;
    logic [9:0]         dy;
    logic [9:0]         dx;
  } blit_cmd_t;

  typedef struct packed {
    logic [7:0] pixel;
    logic       status;
  } blit_result_t;

  logic                 clk;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  // dest_x, dest_y, src_x, src_y, rect_w, rect_h, fill_colour, plane_mask,
  // shift_x, shift_y, zero padding above
  logic [103:0]         in_tdata   = '0;
  // req_type
  logic [2:0]           in_tuser   = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  // pixel_value
  logic [7:0]           out_tdata;
  // status
  logic                 out_tuser;
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [DIM_W-1:0]     cfg_data   = '0;

  framebuffer_rect_fill_copy_engine uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Shadow of the engine: its own frame store, the surface size that was
  // last written, and a row buffer for the memmove-style row copies.
  logic [7:0]  shadow_frame [STORE_BYTES];
  logic [7:0]  row_hold [ROW_BUF];
  int unsigned shadow_w = RESET_WIDTH;
  int unsigned shadow_h = RESET_HEIGHT;

  blit_cmd_t    cmd_backlog [$];
  blit_result_t expected_results [$];
  blit_cmd_t    cur_cmd;
  blit_result_t due;

  // Transaction counts. Each is advanced by exactly one process.
  int unsigned pushed_total   = 0;
  int unsigned offered_total  = 0;
  int unsigned accepted_total = 0;
  int unsigned results_total  = 0;
  int unsigned fail_count     = 0;

  // Idling state of the two sides, and the long receiver hold-off.
  int unsigned tx_gap = 0, tx_burst = 0;
  int unsigned rx_gap = 0, rx_burst = 0, rx_seen = 0;
  int unsigned rx_hold_left = 0;
  bit          hold_done = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Shadow model of the engine
  // ---------------------------------------------------------------------

  // Pixel addresses wrap modulo the store size, exactly as the engine's do.
  function automatic int unsigned pix_addr(int unsigned x, int unsigned y);
    return (y * shadow_w + x) % STORE_BYTES;
  endfunction

  function automatic bit rect_fits(int unsigned x, int unsigned y,
                                   int unsigned w, int unsigned h);
    return (x + w <= shadow_w) && (y + h <= shadow_h);
  endfunction

  // A masked fill keeps the planes outside the mask and forces the planes
  // inside it to the matching colour bits.
  function automatic void paint_rect(int unsigned x, int unsigned y,
                                     int unsigned w, int unsigned h,
                                     logic [7:0] colour, logic [3:0] mask,
                                     bit masked);
    logic [7:0]  planes;
    int unsigned r, k, a;
    planes = {4'h0, mask & PLANE_ALL};
    for (r = 0; r < h; r++) begin
      for (k = 0; k < w; k++) begin
        a = pix_addr(x + k, y + r);
        if (masked) begin
          shadow_frame[a] = (shadow_frame[a] & ~planes) | (colour & planes);
        end else begin
          shadow_frame[a] = colour;
        end
      end
    end
  endfunction

  // Each row is read in full before any of it is written back.
  function automatic void move_row(int unsigned dx, int unsigned dy,
                                   int unsigned sx, int unsigned sy,
                                   int unsigned w);
    int unsigned i;
    for (i = 0; i < w; i++) row_hold[i] = shadow_frame[pix_addr(sx + i, sy)];
    for (i = 0; i < w; i++) shadow_frame[pix_addr(dx + i, dy)] = row_hold[i];
  endfunction

  // Rows go top-down when the source lies below the destination, and
  // bottom-up otherwise, so an overlapping copy never reads its own output.
  function automatic void move_rect(int unsigned dx, int unsigned dy,
                                    int unsigned sx, int unsigned sy,
                                    int unsigned w, int unsigned h);
    int unsigned r;
    if (sy > dy) begin
      for (r = 0; r < h; r++) move_row(dx, dy + r, sx, sy + r, w);
    end else begin
      for (r = h; r > 0; r--) move_row(dx, dy + r - 1, sx, sy + r - 1, w);
    end
  endfunction

  // Applies one command to the shadow store and returns the result that
  // the engine has to deliver for it.
  function automatic blit_result_t blit_apply(blit_cmd_t c);
    blit_result_t r;
    int unsigned  w, h, x0, y0, xs, ys;
    int           shift_x, shift_y, ax, ay, cw, ch;
    r.pixel  = 8'h00;
    r.status = 1'b0;
    w = c.w;
    h = c.h;
    case (c.kind)
      REQ_READ: begin
        if (c.dx < shadow_w && c.dy < shadow_h) begin
          r.pixel = shadow_frame[pix_addr(c.dx, c.dy)];
        end else begin
          r.status = 1'b1;
        end
      end
      REQ_FILL, REQ_MFILL: begin
        // An empty rectangle is done before any bounds check is made.
        if (w != 0 && h != 0) begin
          if (!rect_fits(c.dx, c.dy, w, h)) begin
            r.status = 1'b1;
          end else begin
            paint_rect(c.dx, c.dy, w, h, c.colour, c.mask, c.kind == REQ_MFILL);
          end
        end
      end
      REQ_COPY: begin
        if (w != 0 && h != 0) begin
          if (!rect_fits(c.dx, c.dy, w, h) || !rect_fits(c.sx, c.sy, w, h)) begin
            r.status = 1'b1;
          end else begin
            move_rect(c.dx, c.dy, c.sx, c.sy, w, h);
          end
        end
      end
      REQ_SCROLL: begin
        shift_x = c.shx;
        shift_y = c.shy;
        ax = (shift_x < 0) ? -shift_x : shift_x;
        ay = (shift_y < 0) ? -shift_y : shift_y;
        cw = int'(shadow_w) - ax;
        ch = int'(shadow_h) - ay;
        // A shift at least as large as the dimension leaves nothing to move.
        if (cw > 0 && ch > 0) begin
          if (shift_x > 0) begin
            x0 = 0;
            xs = shift_x;
          end else begin
            x0 = ax;
            xs = 0;
          end
          if (shift_y > 0) begin
            y0 = 0;
            ys = shift_y;
          end else begin
            y0 = ay;
            ys = 0;
          end
          move_rect(x0, y0, xs, ys, cw, ch);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Command generation
  // ---------------------------------------------------------------------

  function automatic blit_cmd_t make_cmd(logic [2:0] kind, int dx, int dy,
                                         int sx, int sy, int w, int h,
                                         int colour, int mask, int shx, int shy);
    blit_cmd_t c;
    c.kind   = kind;
    c.dx     = dx;
    c.dy     = dy;
    c.sx     = sx;
    c.sy     = sy;
    c.w      = w;
    c.h      = h;
    c.colour = colour;
    c.mask   = mask;
    c.shx    = shx;
    c.shy    = shy;
    return c;
  endfunction

  // Mostly small extents, now and then anything up to the full dimension.
  function automatic int unsigned pick_extent(int unsigned dim);
    if ($urandom_range(0, 15) == 0) return $urandom_range(1, dim);
    return $urandom_range(1, (dim < 16) ? dim : 16);
  endfunction

  // A position a few pixels from p, kept inside 0..hi, so that copies often
  // overlap their own source.
  function automatic int unsigned near_pos(int unsigned p, int unsigned hi);
    int v;
    v = int'(p) + int'($urandom_range(0, 6)) - 3;
    if (v < 0) v = 0;
    if (v > int'(hi)) v = hi;
    return v;
  endfunction

  // Three commands in four are well formed for the current surface; the
  // rest keep their fully random fields, which mostly get rejected.
  function automatic blit_cmd_t random_cmd();
    blit_cmd_t   c;
    int unsigned pick, w, h, mag;
    int          cw, ch, ax, ay;
    c.dx     = $urandom_range(0, 1023);
    c.dy     = $urandom_range(0, 1023);
    c.sx     = $urandom_range(0, 1023);
    c.sy     = $urandom_range(0, 1023);
    c.w      = ($urandom_range(0, 9) == 0) ? 1024 : $urandom_range(0, 1024);
    c.h      = ($urandom_range(0, 9) == 0) ? 1024 : $urandom_range(0, 1024);
    c.colour = $urandom_range(0, 255);
    c.mask   = $urandom_range(0, 15);
    c.shx    = int'($urandom_range(0, 2048)) - 1024;
    c.shy    = int'($urandom_range(0, 2048)) - 1024;
    pick = $urandom_range(0, 99);
    if (pick < 28) c.kind = REQ_READ;
    else if (pick < 48) c.kind = REQ_FILL;
    else if (pick < 63) c.kind = REQ_MFILL;
    else if (pick < 83) c.kind = REQ_COPY;
    else if (pick < 97) c.kind = REQ_SCROLL;
    else c.kind = $urandom_range(KIND_RESERVED_LO, KIND_RESERVED_HI);

    if ($urandom_range(0, 3) != 0) begin
      case (c.kind)
        REQ_READ: begin
          c.dx = $urandom_range(0, shadow_w - 1);
          c.dy = $urandom_range(0, shadow_h - 1);
        end
        REQ_FILL, REQ_MFILL, REQ_COPY: begin
          w = pick_extent(shadow_w);
          h = pick_extent(shadow_h);
          c.w  = w;
          c.h  = h;
          c.dx = $urandom_range(0, shadow_w - w);
          c.dy = $urandom_range(0, shadow_h - h);
          if ($urandom_range(0, 1)) begin
            c.sx = near_pos(c.dx, shadow_w - w);
            c.sy = near_pos(c.dy, shadow_h - h);
          end else begin
            c.sx = $urandom_range(0, shadow_w - w);
            c.sy = $urandom_range(0, shadow_h - h);
          end
        end
        REQ_SCROLL: begin
          mag   = shadow_w - pick_extent(shadow_w);
          c.shx = $urandom_range(0, 1) ? int'(mag) : -int'(mag);
          mag   = shadow_h - pick_extent(shadow_h);
          c.shy = $urandom_range(0, 1) ? int'(mag) : -int'(mag);
        end
        default: ;
      endcase
    end

    // Keep anything that would really run under the area cap.
    w = c.w;
    h = c.h;
    if ((c.kind == REQ_FILL || c.kind == REQ_MFILL || c.kind == REQ_COPY) &&
        w != 0 && h != 0 && w * h > AREA_CAP && rect_fits(c.dx, c.dy, w, h) &&
        (c.kind != REQ_COPY || rect_fits(c.sx, c.sy, w, h))) begin
      c.h = $urandom_range(1, AREA_CAP / w);
    end
    if (c.kind == REQ_SCROLL) begin
      ax = (c.shx < 0) ? -int'(c.shx) : int'(c.shx);
      ay = (c.shy < 0) ? -int'(c.shy) : int'(c.shy);
      cw = int'(shadow_w) - ax;
      ch = int'(shadow_h) - ay;
      if (cw > 0 && ch > 0 && cw * ch > int'(AREA_CAP)) begin
        mag   = $urandom_range(shadow_w, 1024);
        c.shx = $urandom_range(0, 1) ? int'(mag) : -int'(mag);
      end
    end
    return c;
  endfunction

  // Idle cycles before the next transaction, with occasional bursts of
  // back-to-back transactions.
  function automatic int unsigned draw_gap(inout int unsigned burst);
    if (burst != 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) burst = $urandom_range(10, 30);
    return $urandom_range(0, 11);
  endfunction

  // ---------------------------------------------------------------------
  // Driver: presents queued commands on the input channel at the falling
  // edge. A command counts as taken once the monitor has seen it accepted.
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && accepted_total == offered_total) begin
        tx_gap = draw_gap(tx_burst);
      end
      if (!in_tvalid || accepted_total == offered_total) begin
        if (tx_gap != 0) begin
          tx_gap--;
          in_tvalid <= 1'b0;
        end else if (cmd_backlog.size() != 0) begin
          cur_cmd = cmd_backlog.pop_front();
          in_tdata <= {6'd0, cur_cmd.shy, cur_cmd.shx, cur_cmd.mask, cur_cmd.colour,
                       cur_cmd.h, cur_cmd.w, cur_cmd.sy, cur_cmd.sx, cur_cmd.dy,
                       cur_cmd.dx};
          in_tuser  <= cur_cmd.kind;
          in_tvalid <= 1'b1;
          offered_total++;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: after each result transaction it waits a random number of
  // cycles before it is ready again, unless the long hold-off is running.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (results_total != rx_seen) begin
        rx_seen = results_total;
        rx_gap  = draw_gap(rx_burst);
      end
      if (rx_hold_left != 0) begin
        out_tready <= 1'b0;
      end else if (rx_gap != 0) begin
        rx_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Once, part way through the run, the receiver stops for a long stretch
  // while the driver keeps offering commands. The engine takes one more
  // command while a result waits in its output register and then has to stall its input.
  always @(negedge clk) begin
    if (!hold_done && accepted_total >= HOLD_AFTER) begin
      rx_hold_left <= HOLD_CYCLES;
      hold_done    <= 1'b1;
    end else if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
    end
  end

  // Monitor: at each rising edge it first checks a result transaction
  // against the oldest prediction and then predicts for a command accepted
  // at the same edge, so the two can never be confused.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        results_total++;
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("result %0d arrived with no command outstanding: pixel %02h status %0d",
                     results_total, out_tdata, out_tuser);
          end
        end else begin
          due = expected_results.pop_front();
          if (out_tdata !== due.pixel || out_tuser !== due.status) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("mismatch on result %0d: pixel %02h status %0d, expected pixel %02h status %0d",
                       results_total, out_tdata, out_tuser, due.pixel, due.status);
            end
          end
        end
      end
      if (in_tvalid && in_tready) begin
        accepted_total++;
        expected_results.push_back(blit_apply(cur_cmd));
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus sequence
  // ---------------------------------------------------------------------

  task automatic push_cmd(input blit_cmd_t c);
    cmd_backlog.push_back(c);
    pushed_total++;
  endtask

  // Returns once every queued command has been taken and every result has
  // been consumed, then lets the engine settle.
  task automatic wait_drained();
    while (accepted_total != pushed_total || results_total != accepted_total) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_surface(input int unsigned w, input int unsigned h);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_WIDTH;
    cfg_data  <= w;
    @(negedge clk);
    cfg_index <= CFG_HEIGHT;
    cfg_data  <= h;
    @(negedge clk);
    cfg_we <= 1'b0;
    shadow_w = w;
    shadow_h = h;
  endtask

  initial begin
    int unsigned ph, sw, sh, k;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, on the 320 by 200 surface left by reset. The first
    // fill defines every byte that this surface can reach.
    push_cmd(make_cmd(REQ_FILL, 0, 0, 0, 0, 320, 200, 8'h3C, 0, 0, 0));
    push_cmd(make_cmd(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    push_cmd(make_cmd(REQ_READ, 319, 199, 0, 0, 0, 0, 0, 0, 0, 0));
    // Reads just outside the surface, and at the far corner of the fields.
    push_cmd(make_cmd(REQ_READ, 320, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    push_cmd(make_cmd(REQ_READ, 0, 200, 0, 0, 0, 0, 0, 0, 0, 0));
    push_cmd(make_cmd(REQ_READ, 1023, 1023, 1023, 1023, 0, 0, 0, 0, 0, 0));
    // Empty rectangles succeed even when their position is out of range.
    push_cmd(make_cmd(REQ_FILL, 1023, 1023, 0, 0, 0, 5, 8'h77, 0, 0, 0));
    push_cmd(make_cmd(REQ_MFILL, 1023, 1023, 0, 0, 5, 0, 8'h77, 4'hF, 0, 0));
    // Rectangles that run off the surface are rejected; one that just fits at the far corner is not.
    push_cmd(make_cmd(REQ_FILL, 0, 0, 0, 0, 1024, 1024, 8'hFF, 0, 0, 0));
    push_cmd(make_cmd(REQ_FILL, 300, 10, 0, 0, 21, 1, 8'h11, 0, 0, 0));
    push_cmd(make_cmd(REQ_MFILL, 0, 190, 0, 0, 1, 11, 8'h11, 4'hF, 0, 0));
    push_cmd(make_cmd(REQ_FILL, 319, 199, 0, 0, 1, 1, 8'hFF, 0, 0, 0));
    push_cmd(make_cmd(REQ_READ, 319, 199, 0, 0, 0, 0, 0, 0, 0, 0));
    // Masked fills with no planes, all planes and a scattered mask.
    push_cmd(make_cmd(REQ_MFILL, 10, 10, 0, 0, 4, 3, 8'hFF, 4'h0, 0, 0));
    push_cmd(make_cmd(REQ_MFILL, 10, 10, 0, 0, 4, 3, 8'hA6, PLANE_ALL, 0, 0));
    push_cmd(make_cmd(REQ_MFILL, 12, 11, 0, 0, 4, 3, 8'h5A, 4'h5, 0, 0));
    push_cmd(make_cmd(REQ_READ, 12, 11, 0, 0, 0, 0, 0, 0, 0, 0));
    // Overlapping copies in both vertical directions and sideways within the same rows.
    push_cmd(make_cmd(REQ_COPY, 8, 10, 10, 12, 6, 4, 0, 0, 0, 0));
    push_cmd(make_cmd(REQ_COPY, 11, 12, 8, 10, 6, 4, 0, 0, 0, 0));
    push_cmd(make_cmd(REQ_COPY, 12, 10, 10, 10, 8, 2, 0, 0, 0, 0));
    push_cmd(make_cmd(REQ_COPY, 10, 10, 12, 10, 8, 2, 0, 0, 0, 0));
    push_cmd(make_cmd(REQ_READ, 13, 11, 0, 0, 0, 0, 0, 0, 0, 0));
    // Copies rejected on the source side and on the destination side, and an empty one that is not.
    push_cmd(make_cmd(REQ_COPY, 0, 0, 316, 0, 5, 1, 0, 0, 0, 0));
    push_cmd(make_cmd(REQ_COPY, 0, 198, 0, 0, 1, 3, 0, 0, 0, 0));
    push_cmd(make_cmd(REQ_COPY, 1023, 1023, 1023, 1023, 0, 1024, 0, 0, 0, 0));
    // A scroll of a small area, then shifts at and beyond the surface size, the reserved kinds and a read.
    push_cmd(make_cmd(REQ_SCROLL, 0, 0, 0, 0, 0, 0, 0, 0, 300, -190));
    push_cmd(make_cmd(REQ_SCROLL, 0, 0, 0, 0, 0, 0, 0, 0, -1024, 1024));
    push_cmd(make_cmd(REQ_SCROLL, 0, 0, 0, 0, 0, 0, 0, 0, 320, 0));
    push_cmd(make_cmd(KIND_RESERVED_LO, 5, 5, 0, 0, 4, 4, 8'h00, 0, 0, 0));
    push_cmd(make_cmd(KIND_RESERVED_HI, 5, 5, 0, 0, 4, 4, 8'h00, 0, 0, 0));
    push_cmd(make_cmd(REQ_READ, 5, 195, 0, 0, 0, 0, 0, 0, 0, 0));
    wait_drained();

    // Random part. Each phase sets a new surface while the engine is idle;
    // the first one is 256 by 256 so that its fill defines the whole store.
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: begin sw = 256;  sh = 256;  end
        1: begin sw = 1;    sh = 1;    end
        2: begin sw = 1024; sh = 1024; end
        3: begin sw = 1024; sh = 1;    end
        4: begin sw = 1;    sh = 1024; end
        default: begin
          sw = $urandom_range(1, 64);
          sh = $urandom_range(1, 64);
          if ($urandom_range(0, 3) == 0) sw = $urandom_range(1, 1024);
        end
      endcase
      write_surface(sw, sh);
      if (ph == 0 || sw * sh <= AREA_CAP) begin
        push_cmd(make_cmd(REQ_FILL, 0, 0, 0, 0, sw, sh, $urandom_range(0, 255), 0, 0, 0));
      end
      if (ph != 0 && sw * sh <= AREA_CAP) begin
        push_cmd(make_cmd(REQ_SCROLL, 0, 0, 0, 0, 0, 0, 0, 0,
                          $urandom_range(0, 1) ? 1 : -1, $urandom_range(0, 1) ? 1 : -1));
      end
      for (k = 0; k < ITEMS_PER_PHASE; k++) push_cmd(random_cmd());
      wait_drained();
    end

    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #(TIMEOUT_UNITS);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
